>>> rtl/core/nftr_pkg.sv
package nftr_pkg;

	localparam int WIN_DEPTH = 10;
	localparam int KIND_COUNT = 4;

	localparam logic [7:0] CHR_QUOTE = 8'h22;
	localparam logic [7:0] CHR_BSLASH = 8'h5c;

	localparam logic [1:0] KIND_NEG_INF = 2'd0;
	localparam logic [1:0] KIND_POS_INF = 2'd1;
	localparam logic [1:0] KIND_NAN_UP = 2'd2;
	localparam logic [1:0] KIND_NAN_LO = 2'd3;

	localparam logic [71:0] TOK_NEG_INF = "-Infinity";
	localparam logic [63:0] TOK_POS_INF = "Infinity";
	localparam logic [23:0] TOK_NAN_UP = "NaN";
	localparam logic [23:0] TOK_NAN_LO = "nan";

	localparam logic [191:0] SUB_NEG_INF = "-1.7976931348623157e+308";
	localparam logic [183:0] SUB_POS_INF = "1.7976931348623157e+308";
	localparam logic [31:0] SUB_NULL = "null";

	typedef struct packed {
		logic [7:0] data;
		logic last;
		logic word;
	} item_t;

	function automatic logic is_word(input logic [7:0] b);
		return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5a) ||
			(b >= 8'h61 && b <= 8'h7a);
	endfunction

	function automatic logic [3:0] tok_len(input logic [1:0] kind);
		logic [3:0] len;
		unique case (kind)
			KIND_NEG_INF: len = 4'd9;
			KIND_POS_INF: len = 4'd8;
			default: len = 4'd3;
		endcase
		return len;
	endfunction

	function automatic logic [7:0] tok_byte(input logic [1:0] kind, input logic [3:0] idx);
		logic [7:0] b;
		b = 8'h00;
		unique case (kind)
			KIND_NEG_INF: if (idx < 4'd9) b = TOK_NEG_INF[8 * (8 - int'(idx)) +: 8];
			KIND_POS_INF: if (idx < 4'd8) b = TOK_POS_INF[8 * (7 - int'(idx)) +: 8];
			KIND_NAN_UP: if (idx < 4'd3) b = TOK_NAN_UP[8 * (2 - int'(idx)) +: 8];
			default: if (idx < 4'd3) b = TOK_NAN_LO[8 * (2 - int'(idx)) +: 8];
		endcase
		return b;
	endfunction

	function automatic logic [4:0] subst_len(input logic [1:0] kind);
		logic [4:0] len;
		unique case (kind)
			KIND_NEG_INF: len = 5'd24;
			KIND_POS_INF: len = 5'd23;
			default: len = 5'd4;
		endcase
		return len;
	endfunction

	function automatic logic [7:0] subst_byte(input logic [1:0] kind, input logic [4:0] idx);
		logic [7:0] b;
		b = 8'h00;
		unique case (kind)
			KIND_NEG_INF: if (idx < 5'd24) b = SUB_NEG_INF[8 * (23 - int'(idx)) +: 8];
			KIND_POS_INF: if (idx < 5'd23) b = SUB_POS_INF[8 * (22 - int'(idx)) +: 8];
			default: if (idx < 5'd4) b = SUB_NULL[8 * (3 - int'(idx)) +: 8];
		endcase
		return b;
	endfunction

endpackage

>>> rtl/core/nftr_front.sv
module nftr_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         in_data,
	input  logic               in_last,
	output logic               item_valid,
	input  logic               item_ready,
	output nftr_pkg::item_t    item
);

	logic valid_s1;
	nftr_pkg::item_t item_s1;

	assign in_ready = !valid_s1 || item_ready;
	assign item_valid = valid_s1;
	assign item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// classify each byte as word or boundary on the way in
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.data <= in_data;
			item_s1.last <= in_last;
			item_s1.word <= nftr_pkg::is_word(in_data);
		end
	end

endmodule

>>> rtl/core/nftr_queue.sv
module nftr_queue #(
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_valid,
	output logic               wr_ready,
	input  nftr_pkg::item_t    wr_item,
	output logic               rd_valid,
	input  logic               rd_ready,
	output nftr_pkg::item_t    rd_item
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	nftr_pkg::item_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic do_wr;
	logic do_rd;

	assign wr_ready = cnt_q != CW'(DEPTH);
	assign rd_valid = cnt_q != '0;
	assign rd_item = mem_q[rd_ptr_q];
	assign do_wr = wr_valid && wr_ready;
	assign do_rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

endmodule

>>> rtl/core/nftr_back.sv
module nftr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  nftr_pkg::item_t    item,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_data,
	output logic               out_last
);

	localparam int WD = nftr_pkg::WIN_DEPTH;

	logic [7:0] win_q [WD];
	logic [WD-1:0] word_q;
	logic [7:0] win_d [WD];
	logic [WD-1:0] word_d;
	logic [3:0] count_q;
	logic instr_q;
	logic esc_q;
	logic prev_q;
	logic flush_q;
	logic seq_busy_q;
	logic [1:0] seq_kind_q;
	logic [4:0] seq_idx_q;
	logic seq_final_q;
	logic out_valid_q;
	logic [7:0] out_data_q;
	logic out_last_q;

	logic emit_ok;
	logic head_ready;
	logic dec;
	logic [nftr_pkg::KIND_COUNT-1:0] match;
	logic tok_hit;
	logic [1:0] tok_kind;
	logic [3:0] consumed;
	logic [3:0] count_after;
	logic pop;
	logic seq_end;
	logic final_dec;

	assign emit_ok = !out_valid_q || out_ready;
	assign head_ready = (count_q == 4'(WD)) || (flush_q && count_q != 4'd0);
	assign dec = head_ready && !seq_busy_q && emit_ok;
	assign seq_end = seq_idx_q == nftr_pkg::subst_len(seq_kind_q) - 5'd1;

	// whole-word token match at the head of the window
	always_comb begin
		logic [3:0] len_k;
		logic eq;
		for (int k = 0; k < nftr_pkg::KIND_COUNT; k++) begin
			len_k = nftr_pkg::tok_len(2'(k));
			eq = 1'b1;
			for (int i = 0; i < WD - 1; i++) begin
				if (4'(i) < len_k && win_q[i] != nftr_pkg::tok_byte(2'(k), 4'(i))) begin
					eq = 1'b0;
				end
			end
			match[k] = eq && (count_q >= len_k) && !prev_q &&
				((count_q > len_k) ? !word_q[len_k] : flush_q);
		end
	end

	always_comb begin
		tok_hit = 1'b0;
		tok_kind = nftr_pkg::KIND_NEG_INF;
		for (int k = nftr_pkg::KIND_COUNT - 1; k >= 0; k--) begin
			if (match[k]) begin
				tok_hit = 1'b1;
				tok_kind = 2'(k);
			end
		end
		tok_hit = tok_hit && !instr_q;
	end

	assign consumed = !dec ? 4'd0 : (tok_hit ? nftr_pkg::tok_len(tok_kind) : 4'd1);
	assign count_after = count_q - consumed;
	assign pop = item_valid && !flush_q && (count_after < 4'(WD));
	assign item_ready = pop;
	assign final_dec = dec && flush_q && (count_after == 4'd0);

	// shift out the consumed bytes and append the new one
	always_comb begin
		for (int i = 0; i < WD; i++) begin
			win_d[i] = win_q[i];
			word_d[i] = word_q[i];
			if (consumed == 4'd1) begin
				win_d[i] = win_q[(i + 1) % WD];
				word_d[i] = word_q[(i + 1) % WD];
			end else if (consumed == 4'd3) begin
				win_d[i] = win_q[(i + 3) % WD];
				word_d[i] = word_q[(i + 3) % WD];
			end else if (consumed == 4'd8) begin
				win_d[i] = win_q[(i + 8) % WD];
				word_d[i] = word_q[(i + 8) % WD];
			end else if (consumed == 4'd9) begin
				win_d[i] = win_q[(i + 9) % WD];
				word_d[i] = word_q[(i + 9) % WD];
			end
			if (pop && count_after == 4'(i)) begin
				win_d[i] = item.data;
				word_d[i] = item.word;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < WD; i++) begin
			win_q[i] <= win_d[i];
		end
		word_q <= word_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 4'd0;
			instr_q <= 1'b0;
			esc_q <= 1'b0;
			prev_q <= 1'b0;
			flush_q <= 1'b0;
			seq_busy_q <= 1'b0;
			seq_kind_q <= nftr_pkg::KIND_NEG_INF;
			seq_idx_q <= 5'd0;
			seq_final_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_after + (pop ? 4'd1 : 4'd0);
			if (pop && item.last) begin
				flush_q <= 1'b1;
			end
			if (dec) begin
				if (instr_q) begin
					if (esc_q) begin
						esc_q <= 1'b0;
					end else if (win_q[0] == nftr_pkg::CHR_BSLASH) begin
						esc_q <= 1'b1;
					end else if (win_q[0] == nftr_pkg::CHR_QUOTE) begin
						instr_q <= 1'b0;
					end
				end else if (!tok_hit && win_q[0] == nftr_pkg::CHR_QUOTE) begin
					instr_q <= 1'b1;
				end
				// every token ends in a letter
				prev_q <= tok_hit ? 1'b1 : word_q[0];
				if (tok_hit) begin
					seq_busy_q <= 1'b1;
					seq_kind_q <= tok_kind;
					seq_idx_q <= 5'd1;
					seq_final_q <= flush_q && (count_q == nftr_pkg::tok_len(tok_kind));
				end
			end
			if (final_dec) begin
				instr_q <= 1'b0;
				esc_q <= 1'b0;
				prev_q <= 1'b0;
				flush_q <= 1'b0;
			end
			if (seq_busy_q && emit_ok) begin
				seq_idx_q <= seq_idx_q + 5'd1;
				if (seq_end) begin
					seq_busy_q <= 1'b0;
				end
			end
			if ((seq_busy_q && emit_ok) || dec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (seq_busy_q && emit_ok) begin
			out_data_q <= nftr_pkg::subst_byte(seq_kind_q, seq_idx_q);
			out_last_q <= seq_final_q && seq_end;
		end else if (dec) begin
			out_data_q <= tok_hit ? nftr_pkg::subst_byte(tok_kind, 5'd0) : win_q[0];
			out_last_q <= !tok_hit && flush_q && (count_q == 4'd1);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;
	assign out_last = out_last_q;

endmodule

>>> rtl/core/json_nonfinite_token_rewriter_top.sv
// Copies a JSON byte stream and, outside strings, rewrites the whole-word tokens -Infinity,
// Infinity, NaN and nan into the largest finite double (negated for -Infinity) or null.
// Bytes pass one per cycle, unless output back-pressure or a token replacement holds them,
// through a ten-byte lookahead window; tlast on the input drains the window and the final
// output byte carries tlast. A matched token sends its replacement bytes (4 for null, up to 24
// for the double text) in turn through the single output register; the input keeps filling
// the window during that time, except while a tlast drain blocks it, and stalls only once the
// queue and the input register are full and the window is full or draining.
module json_nonfinite_token_rewriter_top #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // in_byte
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // out_byte
	output logic       m_tlast
);

	logic front_valid;
	logic front_ready;
	nftr_pkg::item_t front_item;
	logic queue_valid;
	logic queue_ready;
	nftr_pkg::item_t queue_item;

	nftr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_data    (s_tdata),
		.in_last    (s_tlast),
		.item_valid (front_valid),
		.item_ready (front_ready),
		.item       (front_item)
	);

	nftr_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (front_valid),
		.wr_ready (front_ready),
		.wr_item  (front_item),
		.rd_valid (queue_valid),
		.rd_ready (queue_ready),
		.rd_item  (queue_item)
	);

	nftr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (queue_valid),
		.item_ready (queue_ready),
		.item       (queue_item),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_data   (m_tdata),
		.out_last   (m_tlast)
	);

endmodule

>>> test/tb.sv
module tb;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} out_byte_t;

	typedef logic [7:0] text_t[$];

	logic       clk;
	logic       arst_n   = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata  = 8'h00;
	logic       s_tlast  = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;
	logic       m_tlast;

	json_nonfinite_token_rewriter_top u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// token and replacement text, indexed by kind code
	string tok_txt[nftr_pkg::KIND_COUNT] = '{"-Infinity", "Infinity", "NaN", "nan"};
	string sub_txt[nftr_pkg::KIND_COUNT] = '{"-1.7976931348623157e+308",
		"1.7976931348623157e+308", "null", "null"};
	string sep_txt = ",:[]{} \t\n";

	logic [7:0]  win[nftr_pkg::WIN_DEPTH];
	int unsigned win_n     = 0;
	bit          in_str    = 1'b0;
	bit          esc       = 1'b0;
	bit          prev_word = 1'b0;
	out_byte_t   rewritten_q[$];

	bit fast_tx = 1'b0;
	bit fast_rx = 1'b0;
	int rx_hold = 0;
	int errs    = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("status: fail");
		$finish;
	end

	function automatic bit word_char(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic logic [7:0] alnum_byte();
		int unsigned r;
		r = $urandom_range(0, 61);
		if (r < 10)
			return 8'(8'h30 + r);
		else if (r < 36)
			return 8'(8'h41 + (r - 10));
		return 8'(8'h61 + (r - 36));
	endfunction

	function automatic void shift_out(input int unsigned k);
		prev_word = word_char(win[k - 1]);
		for (int unsigned i = 0; i + k < win_n; i++)
			win[i] = win[i + k];
		win_n -= k;
	endfunction

	function automatic void resolve_head(input bit at_end);
		logic [7:0]  c;
		int unsigned len;
		bit          hit;
		c = win[0];
		if (in_str) begin
			if (esc)
				esc = 1'b0;
			else if (c == nftr_pkg::CHR_BSLASH)
				esc = 1'b1;
			else if (c == nftr_pkg::CHR_QUOTE)
				in_str = 1'b0;
			rewritten_q.push_back(out_byte_t'{data: c, last: 1'b0});
			shift_out(1);
			return;
		end
		for (int j = 0; j < nftr_pkg::KIND_COUNT; j++) begin
			len = tok_txt[j].len();
			if (win_n < len || prev_word)
				continue;
			hit = 1'b1;
			for (int unsigned i = 0; i < len; i++)
				if (win[i] != tok_txt[j][i])
					hit = 1'b0;
			if (!hit)
				continue;
			if (win_n > len) begin
				if (word_char(win[len]))
					continue;
			end else if (!at_end) begin
				continue;
			end
			for (int k = 0; k < sub_txt[j].len(); k++)
				rewritten_q.push_back(out_byte_t'{data: sub_txt[j][k], last: 1'b0});
			shift_out(len);
			return;
		end
		if (c == nftr_pkg::CHR_QUOTE)
			in_str = 1'b1;
		rewritten_q.push_back(out_byte_t'{data: c, last: 1'b0});
		shift_out(1);
	endfunction

	function automatic void rewrite_byte(input logic [7:0] b, input logic l);
		int n0;
		win[win_n] = b;
		win_n++;
		while (win_n >= nftr_pkg::WIN_DEPTH)
			resolve_head(1'b0);
		if (l) begin
			n0 = rewritten_q.size();
			while (win_n > 0)
				resolve_head(1'b1);
			if (rewritten_q.size() > n0)
				rewritten_q[rewritten_q.size() - 1].last = 1'b1;
			in_str = 1'b0;
			esc = 1'b0;
			prev_word = 1'b0;
		end
	endfunction

	function automatic text_t make_text();
		text_t t;
		int    target;
		int    pick;
		string s;
		target = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 30);
		while (t.size() < target) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					if ($urandom_range(0, 3) == 0)
						t.push_back(alnum_byte());
					s = tok_txt[$urandom_range(0, nftr_pkg::KIND_COUNT - 1)];
					for (int i = 0; i < s.len(); i++)
						t.push_back(s[i]);
					if ($urandom_range(0, 3) == 0)
						t.push_back(alnum_byte());
				end
				4, 5: begin
					t.push_back(nftr_pkg::CHR_QUOTE);
					repeat ($urandom_range(0, 6)) begin
						pick = $urandom_range(0, 5);
						if (pick == 0) begin
							t.push_back(nftr_pkg::CHR_BSLASH);
							t.push_back(8'($urandom_range(0, 255)));
						end else if (pick == 1) begin
							s = tok_txt[$urandom_range(0, nftr_pkg::KIND_COUNT - 1)];
							for (int i = 0; i < s.len(); i++)
								t.push_back(s[i]);
						end else if (pick == 2) begin
							t.push_back(nftr_pkg::CHR_BSLASH);
							t.push_back(nftr_pkg::CHR_QUOTE);
						end else begin
							t.push_back(alnum_byte());
						end
					end
					if ($urandom_range(0, 4) != 0)
						t.push_back(nftr_pkg::CHR_QUOTE);
				end
				6: repeat ($urandom_range(1, 4)) t.push_back(8'(8'h30 + $urandom_range(0, 9)));
				7: t.push_back(sep_txt[$urandom_range(0, sep_txt.len() - 1)]);
				8: t.push_back(8'($urandom_range(0, 255)));
				default: begin
					// truncated token
					s = tok_txt[$urandom_range(0, nftr_pkg::KIND_COUNT - 1)];
					pick = $urandom_range(1, s.len() - 1);
					for (int i = 0; i < pick; i++)
						t.push_back(s[i]);
				end
			endcase
		end
		return t;
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic l);
		int gap;
		gap = fast_tx ? 0 : $urandom_range(0, 15);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= l;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		rewrite_byte(b, l);
	endtask

	task automatic send_str(input string s, input bit ends);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], ends && i == s.len() - 1);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		wait (rewritten_q.size() == 0);
		@(posedge clk);
	endtask

	task automatic test_tokens();
		send_str("-Infinity", 1'b1);
		send_str("Infinity", 1'b1);
	endtask

	task automatic test_boundaries();
		send_byte(8'h00, 1'b0);
		send_str("NaN,nan", 1'b0);
		send_byte(8'hff, 1'b1);
	endtask

	task automatic test_strings();
		// unterminated string with an escaped quote
		send_str("\"nan\\\"x", 1'b1);
	endtask

	task automatic test_backpressure();
		fast_tx = 1'b1;
		rx_hold = 300;
		repeat (3) send_str("[-Infinity,NaN]", 1'b0);
		send_str("nan", 1'b1);
		fast_tx = 1'b0;
		wait_drained();
	endtask

	task automatic test_random();
		text_t t;
		int    sent;
		sent = 0;
		while (sent < 220) begin
			t = make_text();
			fast_tx = ($urandom_range(0, 3) == 0);
			fast_rx = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < t.size(); i++)
				send_byte(t[i], ($urandom_range(0, 5) != 0) && i == t.size() - 1);
			sent += t.size();
			if ($urandom_range(0, 7) == 0)
				wait_drained();
		end
		send_byte(8'h20, 1'b1);
	endtask

	initial begin : rx_side
		int        stall;
		out_byte_t exp;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (rx_hold > 0) begin
				m_tready <= 1'b0;
				repeat (rx_hold) @(posedge clk);
				rx_hold = 0;
			end else begin
				stall = fast_rx ? 0 : $urandom_range(0, 15);
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid)
				@(posedge clk);
			if (rewritten_q.size() == 0) begin
				$display("%0t: unexpected transaction byte %h last %b", $time, m_tdata, m_tlast);
				errs++;
			end else begin
				exp = rewritten_q.pop_front();
				if (m_tdata !== exp.data) begin
					$display("%0t: byte expected %h actual %h", $time, exp.data, m_tdata);
					errs++;
				end
				if (m_tlast !== exp.last) begin
					$display("%0t: last expected %b actual %b", $time, exp.last, m_tlast);
					errs++;
				end
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_tokens();
		test_boundaries();
		test_strings();
		test_backpressure();
		test_random();
		s_tvalid <= 1'b0;
		wait (rewritten_q.size() == 0);
		repeat (100) @(posedge clk);
		if (errs == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
